[src/shs_pkg.sv]
// shared types, constants and round functions of the sha-256 stream hasher
`timescale 1ns / 1ps

package shs_pkg;

   localparam int DigestWords = 8;
   localparam int BlockWords  = 16;
   localparam int NumRounds   = 64;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam word_type InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type PadWord   = 32'h80000000;
   localparam logic [2:0] FullWordBytes = 3'd4;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

   // keeps valid leading bytes, 0x80 marker after them; a full word is kept
   function automatic word_type pad_last_word(input word_type w, input logic [2:0] nbytes);
      case (nbytes)
         3'd0:    pad_last_word = PadWord;
         3'd1:    pad_last_word = {w[31:24], 24'h800000};
         3'd2:    pad_last_word = {w[31:16], 16'h8000};
         3'd3:    pad_last_word = {w[31:8], 8'h80};
         default: pad_last_word = w;
      endcase
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h0;
      endcase
   endfunction

endpackage

[src/sha256_stream_hasher.sv]
// sha-256 stream hasher: message words in, eight digest words out per message
//
// requests carry one big-endian message word, a valid-byte count and a last
// flag. a non-last request is taken as four bytes. the last request may hold
// zero to four bytes, so an empty message is a single last request with zero
// bytes. one digest comes out per message as eight responses, word a first,
// with last_word set on the eighth.
// requests are taken only in the idle state. the request that fills a
// 16-word block is followed by the 64 rounds and the fold on the single
// shared round unit, during which no request is taken.
// after the last request the padding and length words are pushed one per
// cycle, held while each filled block is compressed, and one or two blocks
// are compressed before the first digest word shows on rsp_valid.
// req_stall is high for all of that time and while the digest is delivered.
// rsp_stall holds the current digest word; one word goes out per cycle
// when not stalled.
// reset (synchronous) loads the initial hash, clears the bit count and the
// block fill count and drops rsp_valid.
`timescale 1ns / 1ps

module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shs_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // hash state, working variables a..h and the 16-word schedule window
   shs_pkg::word_type chain_ff [shs_pkg::DigestWords];
   shs_pkg::word_type chain_in [shs_pkg::DigestWords];
   shs_pkg::word_type work_ff  [shs_pkg::DigestWords];
   shs_pkg::word_type work_in  [shs_pkg::DigestWords];
   shs_pkg::word_type sched_ff [shs_pkg::BlockWords];
   shs_pkg::word_type sched_in [shs_pkg::BlockWords];

   logic [3:0]  count_ff, count_in;     // words held in the current block
   logic [63:0] bits_ff, bits_in;       // message length in bits, wraps
   logic [5:0]  round_ff, round_in;
   logic        need80_ff, need80_in;   // marker word still owed after a full last word
   logic        hi_done_ff, hi_done_in; // upper length word already pushed
   logic        final_ff, final_in;     // length pushed, digest follows this block
   logic        pad_ff, pad_in;         // message closed, padding in progress
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic              push_en;
   shs_pkg::word_type push_word;
   logic [2:0]        vb_sat;

   // round datapath
   shs_pkg::word_type t1, t2, w_next;

   assign vb_sat = (req_data.valid_bytes > shs_pkg::FullWordBytes) ?
                   shs_pkg::FullWordBytes : req_data.valid_bytes;

   always_comb begin
      t1 = work_ff[7] + shs_pkg::big_sigma1(work_ff[4])
         + shs_pkg::choose(work_ff[4], work_ff[5], work_ff[6])
         + shs_pkg::round_k(round_ff) + sched_ff[0];
      t2 = shs_pkg::big_sigma0(work_ff[0])
         + shs_pkg::majority(work_ff[0], work_ff[1], work_ff[2]);
      // next schedule word, w[t+16], from the sliding window
      w_next = shs_pkg::small_sigma1(sched_ff[14]) + sched_ff[9]
             + shs_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];
   end

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      count_in     = count_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      need80_in    = need80_ff;
      hi_done_in   = hi_done_ff;
      final_in     = final_ff;
      pad_in       = pad_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      push_en      = 1'b0;
      push_word    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (!req_data.last_item) begin
                  push_word = req_data.message_word;
                  bits_in   = bits_ff + 64'd32;
               end else begin
                  bits_in   = bits_ff + {58'd0, vb_sat, 3'b000};
                  push_word = shs_pkg::pad_last_word(req_data.message_word, vb_sat);
                  need80_in = (vb_sat == shs_pkg::FullWordBytes);
                  pad_in    = 1'b1;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (need80_ff) begin
               push_word = shs_pkg::PadWord;
               need80_in = 1'b0;
            end else if (count_ff == 4'd14) begin
               push_word  = bits_ff[63:32];
               hi_done_in = 1'b1;
            end else if (count_ff == 4'd15 && hi_done_ff) begin
               push_word = bits_ff[31:0];
               final_in  = 1'b1;
            end else begin
               // zero fill, also closes a block with no room for the length
               push_word = '0;
            end
         end
         ST_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            for (int i = 0; i < shs_pkg::BlockWords - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[shs_pkg::BlockWords - 1] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(shs_pkg::NumRounds - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < shs_pkg::DigestWords; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (final_ff) begin
               state_in     = ST_OUT;
               out_idx_in   = '0;
               rsp_valid_in = 1'b1;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (out_idx_ff == 3'(shs_pkg::DigestWords - 1)) begin
                  // digest delivered: start over for the next message
                  chain_in     = shs_pkg::InitHash;
                  count_in     = '0;
                  bits_in      = '0;
                  hi_done_in   = 1'b0;
                  final_in     = 1'b0;
                  pad_in       = 1'b0;
                  need80_in    = 1'b0;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // block fill; the sixteenth word starts the compression
      if (push_en) begin
         sched_in[count_ff] = push_word;
         if (count_ff == 4'(shs_pkg::BlockWords - 1)) begin
            count_in = '0;
            work_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= shs_pkg::InitHash;
         count_ff     <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         need80_ff    <= 1'b0;
         hi_done_ff   <= 1'b0;
         final_ff     <= 1'b0;
         pad_ff       <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         need80_ff    <= need80_in;
         hi_done_ff   <= hi_done_in;
         final_ff     <= final_in;
         pad_ff       <= pad_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ready only between messages or between words of an open block
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == 3'(shs_pkg::DigestWords - 1));

`ifndef SYNTHESIS
   // no request is taken while a digest is being delivered
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request window open during digest output");

   // the last round always hands over to the fold
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'(shs_pkg::NumRounds - 1))
      |=> (state_ff == ST_FOLD))
      else $error("compression did not end after the last round");

   // delivering the final digest word leaves a fresh message state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_word)
      |=> (count_ff == 4'd0 && bits_ff == 64'd0 && !rsp_valid))
      else $error("message state not cleared after digest");

   // a digest is only started once the length words were pushed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (final_ff && hi_done_ff && count_ff == 4'd0))
      else $error("digest output without complete padding");
`endif

endmodule
